// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset held off.
`define AM_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle implication failed");

// Next-cycle implication, reset held off.
`define AM_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

// ===== sv/dwc_pkg.sv =====
// Shared types and constants for the depthwise convolution window.
// No dependencies; imported by every module of the block.
package dwc_pkg;

    localparam int POS_W  = 7;
    localparam int TAP_W  = 3;
    localparam int DATA_W = 16;
    localparam int PROD_W = 32;
    localparam int SUM_W  = 38;
    localparam int CRD_W  = 12;   // signed image coordinate, holds every reachable value
    localparam int K_W    = 4;    // effective filter side, up to 7
    localparam int DIM_W  = 11;   // effective image side, up to MAX_DIM

    localparam logic [1:0] ACT_LOAD_TAP = 2'd0;
    localparam logic [1:0] ACT_LOAD_PIX = 2'd1;
    localparam logic [1:0] ACT_REQUEST  = 2'd2;

    localparam logic [2:0] REG_FILTER_SIZE = 3'd0;
    localparam logic [2:0] REG_PAD_AMOUNT  = 3'd1;
    localparam logic [2:0] REG_DILATION    = 3'd2;
    localparam logic [2:0] REG_STRIDE      = 3'd3;
    localparam logic [2:0] REG_IMG_HEIGHT  = 3'd4;
    localparam logic [2:0] REG_IMG_WIDTH   = 3'd5;

    localparam logic [2:0] RST_FILTER_SIZE = 3'd5;
    localparam logic [1:0] RST_PAD_AMOUNT  = 2'd1;
    localparam logic [1:0] RST_DILATION    = 2'd1;
    localparam logic [2:0] RST_STRIDE      = 3'd1;
    localparam logic [7:0] RST_IMG_HEIGHT  = 8'd83;
    localparam logic [7:0] RST_IMG_WIDTH   = 8'd83;

    // Effective geometry after clamping the raw registers.
    typedef struct packed {
        logic [K_W-1:0]   k;
        logic [1:0]       pad;
        logic [1:0]       dil;
        logic [2:0]       stride;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] w;
    } t_cfg;

    typedef struct packed {
        logic clr;     // start a fresh sum
        logic tap_v;   // tap issued this cycle lies inside the image
    } t_mac_ctl;

endpackage

// ===== sv/dwc_store.sv =====
// Image plane and tap weight memories: one write port, one registered read port each.
// Depends on dwc_pkg.
module dwc_store #(
    parameter int MAX_DIM = 128,
    parameter int MAX_K   = 7,
    parameter int AW      = $clog2(MAX_DIM * MAX_DIM),
    parameter int TAW     = (MAX_K > 1) ? $clog2(MAX_K * MAX_K) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_accept,
    input  logic [1:0]                        i_action,
    input  logic [dwc_pkg::POS_W-1:0]         i_pos_row,
    input  logic [dwc_pkg::POS_W-1:0]         i_pos_col,
    input  logic [dwc_pkg::TAP_W-1:0]         i_tap_row,
    input  logic [dwc_pkg::TAP_W-1:0]         i_tap_col,
    input  logic signed [dwc_pkg::DATA_W-1:0] i_data_value,
    input  logic [AW-1:0]                     i_img_raddr,
    input  logic [TAW-1:0]                    i_tap_raddr,
    output logic signed [dwc_pkg::DATA_W-1:0] o_pix,
    output logic signed [dwc_pkg::DATA_W-1:0] o_wt
);
    import dwc_pkg::*;

    localparam int IMG_DEPTH = MAX_DIM * MAX_DIM;
    localparam int TAP_DEPTH = MAX_K * MAX_K;

    logic signed [DATA_W-1:0] r_img_mem [IMG_DEPTH];
    logic signed [DATA_W-1:0] r_tap_mem [TAP_DEPTH];
    logic signed [DATA_W-1:0] r_img_q;
    logic signed [DATA_W-1:0] r_tap_q;

    logic           w_pix_we;
    logic           w_tap_we;
    logic [AW-1:0]  w_img_waddr;
    logic [TAW-1:0] w_tap_waddr;

    // Drop loads that fall outside the stored plane or filter.
    assign w_pix_we = i_accept && (i_action == ACT_LOAD_PIX)
                      && (32'(i_pos_row) < MAX_DIM) && (32'(i_pos_col) < MAX_DIM);
    assign w_tap_we = i_accept && (i_action == ACT_LOAD_TAP)
                      && (32'(i_tap_row) < MAX_K) && (32'(i_tap_col) < MAX_K);

    assign w_img_waddr = AW'(AW'(i_pos_row) * AW'(MAX_DIM) + AW'(i_pos_col));
    assign w_tap_waddr = TAW'(TAW'(i_tap_row) * TAW'(MAX_K) + TAW'(i_tap_col));

    always_ff @(posedge i_clk) begin
        if (w_pix_we) begin
            r_img_mem[w_img_waddr] <= i_data_value;
        end
        r_img_q <= r_img_mem[i_img_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_tap_we) begin
            r_tap_mem[w_tap_waddr] <= i_data_value;
        end
        r_tap_q <= r_tap_mem[i_tap_raddr];
    end

    assign o_pix = r_img_q;
    assign o_wt  = r_tap_q;

endmodule

// ===== sv/dwc_mac.sv =====
// Multiply-accumulate stage: registered product, then exact 38-bit sum.
// Depends on dwc_pkg.
module dwc_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dwc_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [dwc_pkg::DATA_W-1:0] i_pix,
    input  logic signed [dwc_pkg::DATA_W-1:0] i_wt,
    output logic signed [dwc_pkg::SUM_W-1:0]  o_acc
);
    import dwc_pkg::*;

    logic                     r_v1;
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_acc;

    // Valid trails the issue into the next cycle to line up with memory read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.tap_v;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= PROD_W'(i_pix) * PROD_W'(i_wt);
        end
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + SUM_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== sv/dwc_seq.sv =====
// Request sequencer: grid check, tap walk with address generation, output register.
// Depends on dwc_pkg.
module dwc_seq #(
    parameter int MAX_DIM = 128,
    parameter int MAX_K   = 7,
    parameter int AW      = $clog2(MAX_DIM * MAX_DIM),
    parameter int TAW     = (MAX_K > 1) ? $clog2(MAX_K * MAX_K) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dwc_pkg::t_cfg                     i_cfg,
    input  logic                              i_accept,
    input  logic [1:0]                        i_action,
    input  logic [dwc_pkg::POS_W-1:0]         i_pos_row,
    input  logic [dwc_pkg::POS_W-1:0]         i_pos_col,
    input  logic                              i_out_stall,
    input  logic signed [dwc_pkg::SUM_W-1:0]  i_acc,
    output logic                              o_in_stall,
    output logic [AW-1:0]                     o_img_raddr,
    output logic [TAW-1:0]                    o_tap_raddr,
    output dwc_pkg::t_mac_ctl                 o_mac,
    output logic                              o_out_valid,
    output logic signed [dwc_pkg::SUM_W-1:0]  o_sum_value,
    output logic                              o_status
);
    import dwc_pkg::*;

    localparam int RW  = $clog2(MAX_DIM);
    localparam int KIW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]              r_state,    n_state;
    logic [POS_W-1:0]        r_prow,     n_prow;
    logic [POS_W-1:0]        r_pcol,     n_pcol;
    logic [CRD_W-1:0]        r_row,      n_row;
    logic [CRD_W-1:0]        r_col,      n_col;
    logic [CRD_W-1:0]        r_col_base, n_col_base;
    logic [KIW-1:0]          r_kr,       n_kr;
    logic [KIW-1:0]          r_kc,       n_kc;
    logic                    r_drain,    n_drain;
    logic                    r_err,      n_err;
    logic                    r_out_valid, n_out_valid;
    logic signed [SUM_W-1:0] r_sum,      n_sum;
    logic                    r_status,   n_status;

    logic [K_W-1:0]   w_k_m1;
    logic [CRD_W-1:0] w_span;
    logic [CRD_W-1:0] w_prs_r;
    logic [CRD_W-1:0] w_prs_c;
    logic [CRD_W-1:0] w_lim_r;
    logic [CRD_W-1:0] w_lim_c;
    logic             w_grid_ok;
    logic             w_row_in;
    logic             w_col_in;
    logic             w_last_kc;
    logic             w_last_kr;

    // Position is in the grid when its last tap still reaches the padded image.
    assign w_k_m1   = i_cfg.k - K_W'(1);
    assign w_span   = CRD_W'(i_cfg.dil) * CRD_W'(w_k_m1);
    assign w_prs_r  = CRD_W'(r_prow) * CRD_W'(i_cfg.stride);
    assign w_prs_c  = CRD_W'(r_pcol) * CRD_W'(i_cfg.stride);
    assign w_lim_r  = CRD_W'(i_cfg.h) + CRD_W'({i_cfg.pad, 1'b0});
    assign w_lim_c  = CRD_W'(i_cfg.w) + CRD_W'({i_cfg.pad, 1'b0});
    assign w_grid_ok = (w_prs_r + w_span + CRD_W'(1) <= w_lim_r)
                       && (w_prs_c + w_span + CRD_W'(1) <= w_lim_c);

    assign w_row_in  = !r_row[CRD_W-1] && (r_row < CRD_W'(i_cfg.h));
    assign w_col_in  = !r_col[CRD_W-1] && (r_col < CRD_W'(i_cfg.w));
    assign w_last_kc = (K_W'(r_kc) == w_k_m1);
    assign w_last_kr = (K_W'(r_kr) == w_k_m1);

    assign o_img_raddr = AW'(AW'(r_row[RW-1:0]) * AW'(MAX_DIM) + AW'(r_col[RW-1:0]));
    assign o_tap_raddr = TAW'(TAW'(r_kr) * TAW'(MAX_K) + TAW'(r_kc));

    assign o_mac.clr   = (r_state == S_SETUP);
    assign o_mac.tap_v = (r_state == S_RUN) && w_row_in && w_col_in;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sum_value = r_sum;
    assign o_status    = r_status;

    always_comb begin
        n_state     = r_state;
        n_prow      = r_prow;
        n_pcol      = r_pcol;
        n_row       = r_row;
        n_col       = r_col;
        n_col_base  = r_col_base;
        n_kr        = r_kr;
        n_kc        = r_kc;
        n_drain     = r_drain;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_sum       = r_sum;
        n_status    = r_status;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_accept && (i_action == ACT_REQUEST)) begin
                    n_prow  = i_pos_row;
                    n_pcol  = i_pos_col;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_row      = w_prs_r - CRD_W'(i_cfg.pad);
                n_col      = w_prs_c - CRD_W'(i_cfg.pad);
                n_col_base = w_prs_c - CRD_W'(i_cfg.pad);
                n_kr       = '0;
                n_kc       = '0;
                n_err      = !w_grid_ok;
                n_state    = w_grid_ok ? S_RUN : S_DONE;
            end
            S_RUN: begin
                if (w_last_kc) begin
                    n_kc  = '0;
                    n_col = r_col_base;
                    if (w_last_kr) begin
                        n_drain = 1'b0;
                        n_state = S_DRAIN;
                    end else begin
                        n_kr  = r_kr + KIW'(1);
                        n_row = r_row + CRD_W'(i_cfg.dil);
                    end
                end else begin
                    n_kc  = r_kc + KIW'(1);
                    n_col = r_col + CRD_W'(i_cfg.dil);
                end
            end
            S_DRAIN: begin
                // Wait out the read and product stages.
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_sum       = r_err ? '0 : i_acc;
                    n_status    = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_drain     <= 1'b0;
            r_err       <= 1'b0;
            r_kr        <= '0;
            r_kc        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_drain     <= n_drain;
            r_err       <= n_err;
            r_kr        <= n_kr;
            r_kc        <= n_kc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prow     <= n_prow;
        r_pcol     <= n_pcol;
        r_row      <= n_row;
        r_col      <= n_col;
        r_col_base <= n_col_base;
        r_sum      <= n_sum;
        r_status   <= n_status;
    end

endmodule

// ===== sv/depthwise_conv2d_window.sv =====
// Loads (tap or pixel) give no result. A request passes through a setup state, one memory
// read per tap, a drain through the read and product registers, and a done state that
// registers the result once the output is free; outside the output grid it goes from setup
// straight to done. A new item is taken the cycle after the result is registered; no item is
// taken while a request is in progress. Reset restores the configuration registers and
// control state; the memories are not cleared.
module depthwise_conv2d_window #(
    parameter int MAX_DIM = 128,
    parameter int MAX_K   = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [4:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_action,
    input  logic [dwc_pkg::POS_W-1:0]         i_pos_row,
    input  logic [dwc_pkg::POS_W-1:0]         i_pos_col,
    input  logic [dwc_pkg::TAP_W-1:0]         i_tap_row,
    input  logic [dwc_pkg::TAP_W-1:0]         i_tap_col,
    input  logic signed [dwc_pkg::DATA_W-1:0] i_data_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [dwc_pkg::SUM_W-1:0]  o_sum_value,
    output logic                              o_status
);
    import dwc_pkg::*;

    localparam int AW  = $clog2(MAX_DIM * MAX_DIM);
    localparam int TAW = (MAX_K > 1) ? $clog2(MAX_K * MAX_K) : 1;

    logic [2:0] r_filter_size;
    logic [1:0] r_pad_amount;
    logic [1:0] r_dilation_step;
    logic [2:0] r_stride_step;
    logic [7:0] r_image_height;
    logic [7:0] r_image_width;

    logic                    w_cfg_we;
    logic                    w_accept;
    t_cfg                    w_cfg;
    t_mac_ctl                w_mac;
    logic [AW-1:0]           w_img_raddr;
    logic [TAW-1:0]          w_tap_raddr;
    logic signed [DATA_W-1:0] w_pix;
    logic signed [DATA_W-1:0] w_wt;
    logic signed [SUM_W-1:0] w_acc;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;
    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_size   <= RST_FILTER_SIZE;
            r_pad_amount    <= RST_PAD_AMOUNT;
            r_dilation_step <= RST_DILATION;
            r_stride_step   <= RST_STRIDE;
            r_image_height  <= RST_IMG_HEIGHT;
            r_image_width   <= RST_IMG_WIDTH;
        end else if (w_cfg_we) begin
            case (paddr[4:2])
                REG_FILTER_SIZE: r_filter_size   <= pwdata[2:0];
                REG_PAD_AMOUNT:  r_pad_amount    <= pwdata[1:0];
                REG_DILATION:    r_dilation_step <= pwdata[1:0];
                REG_STRIDE:      r_stride_step   <= pwdata[2:0];
                REG_IMG_HEIGHT:  r_image_height  <= pwdata[7:0];
                REG_IMG_WIDTH:   r_image_width   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_FILTER_SIZE: prdata = 32'(r_filter_size);
            REG_PAD_AMOUNT:  prdata = 32'(r_pad_amount);
            REG_DILATION:    prdata = 32'(r_dilation_step);
            REG_STRIDE:      prdata = 32'(r_stride_step);
            REG_IMG_HEIGHT:  prdata = 32'(r_image_height);
            REG_IMG_WIDTH:   prdata = 32'(r_image_width);
            default:         prdata = '0;
        endcase
    end

    // Clamp the raw registers to the geometry the datapath walks.
    always_comb begin
        if (r_filter_size == 3'd0) begin
            w_cfg.k = K_W'(1);
        end else if (32'(r_filter_size) > MAX_K) begin
            w_cfg.k = K_W'(MAX_K);
        end else begin
            w_cfg.k = K_W'(r_filter_size);
        end
        w_cfg.pad    = r_pad_amount;
        w_cfg.dil    = r_dilation_step;
        w_cfg.stride = (r_stride_step == 3'd0) ? 3'd1 : r_stride_step;
        w_cfg.h = (32'(r_image_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_image_height);
        w_cfg.w = (32'(r_image_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(r_image_width);
    end

    dwc_store #(
        .MAX_DIM (MAX_DIM),
        .MAX_K   (MAX_K),
        .AW      (AW),
        .TAW     (TAW)
    ) u_store (
        .i_clk        (i_clk),
        .i_accept     (w_accept),
        .i_action     (i_action),
        .i_pos_row    (i_pos_row),
        .i_pos_col    (i_pos_col),
        .i_tap_row    (i_tap_row),
        .i_tap_col    (i_tap_col),
        .i_data_value (i_data_value),
        .i_img_raddr  (w_img_raddr),
        .i_tap_raddr  (w_tap_raddr),
        .o_pix        (w_pix),
        .o_wt         (w_wt)
    );

    dwc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac),
        .i_pix   (w_pix),
        .i_wt    (w_wt),
        .o_acc   (w_acc)
    );

    dwc_seq #(
        .MAX_DIM (MAX_DIM),
        .MAX_K   (MAX_K),
        .AW      (AW),
        .TAW     (TAW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_accept    (w_accept),
        .i_action    (i_action),
        .i_pos_row   (i_pos_row),
        .i_pos_col   (i_pos_col),
        .i_out_stall (i_out_stall),
        .i_acc       (w_acc),
        .o_in_stall  (o_in_stall),
        .o_img_raddr (w_img_raddr),
        .o_tap_raddr (w_tap_raddr),
        .o_mac       (w_mac),
        .o_out_valid (o_out_valid),
        .o_sum_value (o_sum_value),
        .o_status    (o_status)
    );

endmodule

// ===== sv/dwc_chk.sv =====
// Port-level checker for depthwise_conv2d_window, attached by bind.
// Depends on dwc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dwc_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic [1:0]                        i_action,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [dwc_pkg::SUM_W-1:0]  o_sum_value,
    input logic                              o_status
);
    import dwc_pkg::*;

    // A waiting result beat holds until taken.
    `AM_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_sum_value) && $stable(o_status))

    // An error result carries a zero sum.
    `AM_IMPLIES(a_err_zero, i_clk, i_rst_n, o_out_valid && o_status, o_sum_value == '0)

    // A request beat closes the input.
    `AM_NEXT(a_req_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_action == ACT_REQUEST), o_in_stall)

    // A load or unused-action beat leaves the input open.
    `AM_NEXT(a_load_open, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_action != ACT_REQUEST), !o_in_stall)

endmodule

bind depthwise_conv2d_window dwc_chk u_dwc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_action    (i_action),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_sum_value (o_sum_value),
    .o_status    (o_status)
);

// ===== tb/sv/testbench.sv =====
// Self-checking bench for depthwise_conv2d_window: drives tap, pixel and output-position
// beats with random gaps and result stalls, predicts every windowed sum, checks each result.
// Depends on dwc_pkg and the block's RTL; reads nothing else.
module testbench;
    import dwc_pkg::*;

    localparam int DIM       = 128;
    localparam int KMAX      = 7;
    localparam int CYCLE_CAP = 1_000_000;
    localparam int SETTLE    = 64;    // longer than the slowest request
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [2:0] REG_UNUSED = 3'd6;

    typedef struct packed {
        logic [1:0]               action;
        logic [POS_W-1:0]         pos_row;
        logic [POS_W-1:0]         pos_col;
        logic [TAP_W-1:0]         tap_row;
        logic [TAP_W-1:0]         tap_col;
        logic signed [DATA_W-1:0] data_value;
    } conv_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_value;
        logic                    status;
    } conv_result_t;

    class conv_scoreboard;
        logic [7:0]         regs [6];
        logic signed [15:0] pixels [DIM*DIM];
        logic signed [15:0] weights [KMAX*KMAX];
        bit                 pix_set [DIM*DIM];
        bit                 tap_set [KMAX*KMAX];
        conv_result_t       pending_sums [$];
        int                 fails;

        function void restore_defaults();
            regs[REG_FILTER_SIZE] = 8'(RST_FILTER_SIZE);
            regs[REG_PAD_AMOUNT]  = 8'(RST_PAD_AMOUNT);
            regs[REG_DILATION]    = 8'(RST_DILATION);
            regs[REG_STRIDE]      = 8'(RST_STRIDE);
            regs[REG_IMG_HEIGHT]  = RST_IMG_HEIGHT;
            regs[REG_IMG_WIDTH]   = RST_IMG_WIDTH;
            fails = 0;
        endfunction

        function logic [7:0] reg_mask(logic [2:0] idx);
            case (idx)
                REG_FILTER_SIZE, REG_STRIDE:   return 8'h07;
                REG_PAD_AMOUNT, REG_DILATION:  return 8'h03;
                REG_IMG_HEIGHT, REG_IMG_WIDTH: return 8'hff;
                default:                       return 8'h00;
            endcase
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            if (idx <= REG_IMG_WIDTH) regs[idx] = val[7:0] & reg_mask(idx);
        endfunction

        function int eff_k();
            int k;
            k = int'(regs[REG_FILTER_SIZE]);
            return (k < 1) ? 1 : (k > KMAX) ? KMAX : k;
        endfunction

        function int eff_stride();
            return (regs[REG_STRIDE] == 0) ? 1 : int'(regs[REG_STRIDE]);
        endfunction

        function int eff_h();
            return (regs[REG_IMG_HEIGHT] > DIM) ? DIM : int'(regs[REG_IMG_HEIGHT]);
        endfunction

        function int eff_w();
            return (regs[REG_IMG_WIDTH] > DIM) ? DIM : int'(regs[REG_IMG_WIDTH]);
        endfunction

        function int grid_len(int dim);
            int num;
            num = dim + 2 * int'(regs[REG_PAD_AMOUNT])
                  - int'(regs[REG_DILATION]) * (eff_k() - 1) - 1;
            return (num < 0) ? 0 : num / eff_stride() + 1;
        endfunction

        function void take_item(conv_item_t it);
            conv_result_t res;
            longint acc;
            int orow, ocol, k, s, d, p, h, w, kr, kc, r, c;
            orow = int'(it.pos_row);
            ocol = int'(it.pos_col);
            case (it.action)
                ACT_LOAD_TAP: begin
                    if (it.tap_row < KMAX && it.tap_col < KMAX) begin
                        weights[it.tap_row * KMAX + it.tap_col] = it.data_value;
                        tap_set[it.tap_row * KMAX + it.tap_col] = 1'b1;
                    end
                end
                ACT_LOAD_PIX: begin
                    pixels[orow * DIM + ocol] = it.data_value;
                    pix_set[orow * DIM + ocol] = 1'b1;
                end
                ACT_REQUEST: begin
                    h = eff_h();
                    w = eff_w();
                    k = eff_k();
                    s = eff_stride();
                    d = int'(regs[REG_DILATION]);
                    p = int'(regs[REG_PAD_AMOUNT]);
                    acc = 0;
                    res.status = (orow >= grid_len(h) || ocol >= grid_len(w));
                    if (!res.status) begin
                        for (kr = 0; kr < k; kr++) begin
                            for (kc = 0; kc < k; kc++) begin
                                r = orow * s + kr * d - p;
                                c = ocol * s + kc * d - p;
                                if (r >= 0 && r < h && c >= 0 && c < w)
                                    acc += longint'(pixels[r * DIM + c])
                                         * longint'(weights[kr * KMAX + kc]);
                            end
                        end
                    end
                    res.sum_value = acc[SUM_W-1:0];
                    pending_sums.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void match_result(conv_result_t got);
            conv_result_t want;
            if (pending_sums.size() == 0) begin
                $error("result beat with no request pending: sum_value %0d, status %0d",
                       got.sum_value, got.status);
                fails++;
                return;
            end
            want = pending_sums.pop_front();
            if (got.sum_value !== want.sum_value) begin
                $error("sum_value: expected %0d, got %0d", want.sum_value, got.sum_value);
                fails++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fails++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel, penable, pwrite, pready;
    logic [4:0]              paddr;
    logic [31:0]             pwdata, prdata;
    logic                    in_valid, in_stall;
    logic                    out_valid, out_stall;
    conv_item_t              in_beat;
    logic signed [SUM_W-1:0] sum_value;
    logic                    status;
    bit                      calm = 1'b0;    // no gaps and no stalls while set
    int unsigned             cycle_count = 0;
    conv_scoreboard          sb;

    depthwise_conv2d_window DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_action     (in_beat.action),
        .i_pos_row    (in_beat.pos_row),
        .i_pos_col    (in_beat.pos_col),
        .i_tap_row    (in_beat.tap_row),
        .i_tap_col    (in_beat.tap_col),
        .i_data_value (in_beat.data_value),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_sum_value  (sum_value),
        .o_status     (status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_CAP);
        $display("** depthwise_conv2d_window: FAILED **");
        $finish;
    end

    initial begin : result_side
        int hold;
        conv_result_t got;
        out_stall = 1'b0;
        forever begin
            hold = calm ? 0 : $urandom_range(0, 11);
            if (hold > 0) begin
                out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            out_stall = 1'b0;
            do @(posedge i_clk); while (out_valid !== 1'b1 || i_rst_n !== 1'b1);
            got.sum_value = sum_value;
            got.status    = status;
            sb.match_result(got);
            @(negedge i_clk);
        end
    end

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Call at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input conv_item_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_beat  = it;
        in_valid = 1'b1;
        do @(posedge i_clk); while (in_stall !== 1'b0);
        sb.take_item(it);
        @(negedge i_clk);
    endtask

    task automatic load_tap(input int trow, input int tcol, input logic [15:0] val);
        conv_item_t it;
        it.action     = ACT_LOAD_TAP;
        it.pos_row    = POS_W'($urandom);
        it.pos_col    = POS_W'($urandom);
        it.tap_row    = TAP_W'(trow);
        it.tap_col    = TAP_W'(tcol);
        it.data_value = val;
        send_beat(it);
    endtask

    task automatic load_pixel(input int row, input int col, input logic [15:0] val);
        conv_item_t it;
        it.action     = ACT_LOAD_PIX;
        it.pos_row    = POS_W'(row);
        it.pos_col    = POS_W'(col);
        it.tap_row    = TAP_W'($urandom);
        it.tap_col    = TAP_W'($urandom);
        it.data_value = val;
        send_beat(it);
    endtask

    task automatic stray_beat(input bit all_ones);
        conv_item_t it;
        it        = all_ones ? '1 : conv_item_t'(38'({$urandom, $urandom}));
        it.action = ACT_UNUSED;
        send_beat(it);
    endtask

    // Load each tap and pixel the window will read that is not yet set; flood sets them all to fixed values.
    task automatic prime_window(input int orow, input int ocol, input bit flood,
                                input logic [15:0] pv, input logic [15:0] wv);
        int k, s, d, p, kr, kc, r, c, ti, pi;
        k = sb.eff_k();
        s = sb.eff_stride();
        d = int'(sb.regs[REG_DILATION]);
        p = int'(sb.regs[REG_PAD_AMOUNT]);
        for (kr = 0; kr < k; kr++) begin
            for (kc = 0; kc < k; kc++) begin
                r = orow * s + kr * d - p;
                c = ocol * s + kc * d - p;
                if (r >= 0 && r < sb.eff_h() && c >= 0 && c < sb.eff_w()) begin
                    ti = kr * KMAX + kc;
                    pi = r * DIM + c;
                    if (!sb.tap_set[ti] || (flood && sb.weights[ti] !== wv))
                        load_tap(kr, kc, flood ? wv : rand_word());
                    if (!sb.pix_set[pi] || (flood && sb.pixels[pi] !== pv))
                        load_pixel(r, c, flood ? pv : rand_word());
                end
            end
        end
    endtask

    task automatic request(input int orow, input int ocol);
        conv_item_t it;
        if (orow < sb.grid_len(sb.eff_h()) && ocol < sb.grid_len(sb.eff_w()))
            prime_window(orow, ocol, 1'b0, '0, '0);
        it.action     = ACT_REQUEST;
        it.pos_row    = POS_W'(orow);
        it.pos_col    = POS_W'(ocol);
        it.tap_row    = TAP_W'($urandom);
        it.tap_col    = TAP_W'($urandom);
        it.data_value = DATA_W'($urandom);
        send_beat(it);
    endtask

    task automatic flood_request(input int orow, input int ocol,
                                 input logic [15:0] pv, input logic [15:0] wv);
        prime_window(orow, ocol, 1'b1, pv, wv);
        request(orow, ocol);
    endtask

    task automatic apb_access(input logic [2:0] idx, input logic wr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        paddr   = {idx, 2'b00};
        pwrite  = wr;
        pwdata  = wdata;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        if (wr) sb.write_reg(idx, wdata);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_reg(input logic [2:0] idx, input int val);
        logic [31:0] rd;
        apb_access(idx, 1'b1, ($urandom & ~32'(sb.reg_mask(idx))) | 32'(val), rd);
    endtask

    task automatic check_regs();
        logic [2:0]  ri;
        logic [31:0] rd;
        for (ri = REG_FILTER_SIZE; ri <= REG_IMG_WIDTH; ri++) begin
            apb_access(ri, 1'b0, '0, rd);
            if ((rd[7:0] & sb.reg_mask(ri)) !== sb.regs[ri]) begin
                $error("register %0d: expected %0h, got %0h", ri, sb.regs[ri], rd);
                sb.fails++;
            end
        end
    endtask

    // Drop valid, drain every result, then let any trailing load retire.
    task automatic settle();
        in_valid = 1'b0;
        while (sb.pending_sums.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic configure(input int k, input int p, input int d, input int s,
                             input int h, input int w);
        settle();
        set_reg(REG_FILTER_SIZE, k);
        set_reg(REG_PAD_AMOUNT, p);
        set_reg(REG_DILATION, d);
        set_reg(REG_STRIDE, s);
        set_reg(REG_IMG_HEIGHT, h);
        set_reg(REG_IMG_WIDTH, w);
        set_reg(REG_UNUSED, $urandom);
        check_regs();
    endtask

    task automatic random_phase(input int draws);
        int n, sel, gh, gw, h, w, ar, ac;
        gh = sb.grid_len(sb.eff_h());
        gw = sb.grid_len(sb.eff_w());
        h  = sb.eff_h();
        w  = sb.eff_w();
        // Keep one window per phase so the pixel loads it needs stay few.
        ar = (gh > 0) ? $urandom_range(0, gh - 1) : 0;
        ac = (gw > 0) ? $urandom_range(0, gw - 1) : 0;
        for (n = 0; n < draws; n++) begin
            if ($urandom_range(0, 29) == 0) calm = !calm;
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                if (gh > 0 && gw > 0 && $urandom_range(0, 9) != 0)
                    request(ar, ac);
                else if (gh < DIM)
                    request($urandom_range(gh, DIM - 1), $urandom_range(0, DIM - 1));
                else if (gw < DIM)
                    request($urandom_range(0, DIM - 1), $urandom_range(gw, DIM - 1));
                else
                    request(ar, ac);
            end else if (sel < 75) begin
                if (h > 0 && w > 0 && $urandom_range(0, 3) != 0)
                    load_pixel($urandom_range(0, h - 1), $urandom_range(0, w - 1), rand_word());
                else
                    load_pixel($urandom_range(0, 127), $urandom_range(0, 127), rand_word());
            end else if (sel < 95) begin
                load_tap($urandom_range(0, 7), $urandom_range(0, 7), rand_word());
            end else begin
                stray_beat(1'b0);
            end
        end
        calm = 1'b0;
    endtask

    initial begin : stimulus
        int ph;
        sb = new;
        sb.restore_defaults();
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        in_beat  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        check_regs();

        // Reset geometry: 5x5 taps, pad 1, 83x83 image, 81x81 outputs.
        load_tap(0, 0, 16'h7fff);
        load_tap(6, 6, 16'h8000);
        load_tap(7, 3, 16'h1234);     // tap row past the filter store: dropped
        load_tap(2, 7, 16'h4321);     // tap column past the filter store: dropped
        load_pixel(0, 0, 16'h8000);
        load_pixel(0, 0, 16'h7fff);   // overwrite
        load_pixel(127, 127, 16'h7fff);
        load_pixel(82, 82, 16'hffff);
        stray_beat(1'b1);
        request(0, 0);
        request(80, 80);
        request(81, 5);
        request(3, 81);
        request(127, 127);
        request(0, 127);
        random_phase(20);

        configure(7, 3, 3, 4, 128, 128);
        random_phase(12);
        configure(1, 0, 1, 1, 1, 1);
        random_phase(8);
        configure(0, 2, 0, 0, 0, 5);      // image with no rows, a single tap, zero dilation
        random_phase(8);
        configure(7, 0, 1, 1, 8, 8);
        flood_request(0, 0, 16'h8000, 16'h8000);
        flood_request(0, 0, 16'h8000, 16'h7fff);
        random_phase(8);
        configure(3, 1, 2, 2, 200, 255);  // sides clamp to the store size
        random_phase(12);
        configure(7, 3, 3, 1, 3, 2);      // window wider than the padded image: no grid
        random_phase(8);
        for (ph = 0; ph < 2; ph++) begin
            configure($urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 3),
                      $urandom_range(0, 7), $urandom_range(0, 20), $urandom_range(0, 20));
            random_phase(10);
        end

        settle();
        if (sb.fails == 0)
            $display("** depthwise_conv2d_window: PASSED **");
        else
            $display("** depthwise_conv2d_window: FAILED **");
        $finish;
    end
endmodule
